@@ sv/mcpad_pkg.sv @@
// shared types, constants and the check time helper of the pulse alive detector
package mcpad_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHANNEL_W    = 2;
    localparam int SLOT_COUNT   = 1 << CHANNEL_W;
    localparam int DATA_W       = 16;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_SEL_BIT  = 2;

    localparam logic [DATA_W-1:0] ALIVE_RESET = 16'd1000;
    localparam logic [DATA_W-1:0] TIMER_RESET = 16'd10000;
    localparam logic [DATA_W-1:0] COUNT_MAX   = '1;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic REG_ALIVE = 1'b0;
    localparam logic REG_TIMER = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        word_t edge_count;
        word_t checked_count;
        logic  awaiting_first_edge;
        word_t next_check_time;
        logic  channel_on;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        edge_count:          '0,
        checked_count:       '0,
        awaiting_first_edge: 1'b1,
        next_check_time:     '0,
        channel_on:          1'b0
    };

    typedef struct packed {
        word_t value;
        logic  err;
    } advance_t;

    // base plus alive period, wrapped by one conditional subtraction
    function automatic advance_t advance(word_t base, word_t alive, word_t period);
        logic [DATA_W:0] sum;
        advance_t        res;
        sum = {1'b0, base} + {1'b0, alive};
        if (sum >= {1'b0, period}) begin
            sum = sum - {1'b0, period};
        end
        res.value = sum[DATA_W-1:0];
        res.err   = (base >= period) || (alive >= period);
        return res;
    endfunction

endpackage

@@ sv/multi_channel_pulse_alive_detector.sv @@
// top level of the multi channel pulse alive detector
//
// Usage:
//   The input channel (s_*) takes one event per transfer: a falling edge
//   capture with its timer value, or a compare match check with the pin
//   level. Every event gives exactly one result transfer on the m_* channel
//   with the channel's on state and the next compare value to load.
//   Per channel state sits in a small synchronous memory, read when an event
//   is taken and written back when it leaves the input stage; a back to back
//   event on the same channel takes the written back state from a forwarding
//   register. The event is held in the input stage register, its result in
//   the output register; throughput is one event per cycle while the receiver
//   takes every result, set by the single read and single write memory port.
//   The APB port sets alive_period (0x0) and timer_period (0x4); it is to be
//   written only while no event is in flight, which the block does not enforce.
//   Reset (aresetn low at a clock edge) empties the pipeline, restores the
//   register defaults and marks every channel as waiting for a first edge.
//   When the receiver stalls, the result is held in the output register and
//   one more event may be taken into the memory stage before s_ready falls.
module multi_channel_pulse_alive_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcpad_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mcpad_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mcpad_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [mcpad_pkg::CHANNEL_W-1:0]     s_channel,
    input  logic [mcpad_pkg::DATA_W-1:0]        s_capture_value,
    input  logic                                s_pin_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mcpad_pkg::CHANNEL_W-1:0]     m_result_channel,
    output logic                                m_signal_on,
    output logic                                m_compare_load,
    output logic [mcpad_pkg::DATA_W-1:0]        m_compare_value,
    output logic                                m_compare_armed,
    output logic                                m_range_error
);
    import mcpad_pkg::*;

    word_t alive_period_reg;
    word_t timer_period_reg;
    logic  cfg_write;

    chan_state_t           state_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] mem_valid_reg;
    chan_state_t           rd_data_reg;
    logic                  rd_valid_reg;
    chan_state_t           fwd_data_reg;
    logic                  fwd_hit_reg;

    logic                 s1_valid_reg;
    logic                 s1_operation_reg;
    logic [CHANNEL_W-1:0] s1_channel_reg;
    word_t                s1_capture_reg;
    logic                 s1_pin_reg;

    logic                 m_valid_reg;
    logic [CHANNEL_W-1:0] m_channel_reg;
    logic                 m_on_reg;
    logic                 m_load_reg;
    word_t                m_value_reg;
    logic                 m_armed_reg;
    logic                 m_err_reg;

    logic        accept;
    logic        s1_advance;
    logic        write_en;
    logic        in_range;
    chan_state_t cur;
    chan_state_t state_next;
    advance_t    adv;
    logic        load_next;
    logic        err_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_period_reg <= ALIVE_RESET;
            timer_period_reg <= TIMER_RESET;
        end else if (cfg_write) begin
            case (paddr[REG_SEL_BIT])
                REG_ALIVE: alive_period_reg <= pwdata[DATA_W-1:0];
                REG_TIMER: timer_period_reg <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_ALIVE: prdata = {{(APB_DATA_W-DATA_W){1'b0}}, alive_period_reg};
            REG_TIMER: prdata = {{(APB_DATA_W-DATA_W){1'b0}}, timer_period_reg};
            default:   prdata = '0;
        endcase
    end

    // handshake
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;
    assign in_range   = 32'(s1_channel_reg) < 32'(NUM_CHANNELS);
    assign write_en   = s1_advance && in_range;

    // read modify write of the channel state
    always_comb begin
        if (fwd_hit_reg) begin
            cur = fwd_data_reg;
        end else if (rd_valid_reg) begin
            cur = rd_data_reg;
        end else begin
            cur = CHAN_RESET;
        end

        adv = advance((s1_operation_reg == OP_EDGE) ? s1_capture_reg : cur.next_check_time,
                      alive_period_reg, timer_period_reg);

        state_next = cur;
        load_next  = 1'b0;
        err_next   = 1'b0;

        if (s1_operation_reg == OP_EDGE) begin
            if (cur.edge_count != COUNT_MAX) begin
                state_next.edge_count = cur.edge_count + 1'b1;
            end
            if (cur.awaiting_first_edge) begin
                state_next.next_check_time     = adv.value;
                state_next.awaiting_first_edge = 1'b0;
                load_next                      = 1'b1;
                err_next                       = adv.err;
            end
        end else if (!cur.awaiting_first_edge) begin
            if ((cur.edge_count > cur.checked_count) || !s1_pin_reg) begin
                state_next.channel_on      = 1'b1;
                state_next.checked_count   = cur.edge_count;
                state_next.next_check_time = adv.value;
                load_next                  = 1'b1;
                err_next                   = adv.err;
            end else begin
                state_next = CHAN_RESET;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (write_en) begin
            state_mem[s1_channel_reg] <= state_next;
        end
        if (accept) begin
            rd_data_reg  <= state_mem[s_channel];
            fwd_data_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (write_en) begin
                mem_valid_reg[s1_channel_reg] <= 1'b1;
            end
            if (accept) begin
                rd_valid_reg <= mem_valid_reg[s_channel];
                fwd_hit_reg  <= write_en && (s1_channel_reg == s_channel);
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input stage and output register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_operation_reg <= s_operation;
            s1_channel_reg   <= s_channel;
            s1_capture_reg   <= s_capture_value;
            s1_pin_reg       <= s_pin_level;
        end
        if (s1_advance) begin
            m_channel_reg <= s1_channel_reg;
            m_on_reg      <= in_range && state_next.channel_on;
            m_load_reg    <= in_range && load_next;
            m_value_reg   <= in_range ? state_next.next_check_time : '0;
            m_armed_reg   <= in_range && !state_next.awaiting_first_edge;
            m_err_reg     <= in_range && err_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_channel = m_channel_reg;
    assign m_signal_on      = m_on_reg;
    assign m_compare_load   = m_load_reg;
    assign m_compare_value  = m_value_reg;
    assign m_compare_armed  = m_armed_reg;
    assign m_range_error    = m_err_reg;

endmodule

@@ sv/mcpad_checker.sv @@
// port level checks of the pulse alive detector and their bind
module mcpad_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [mcpad_pkg::CHANNEL_W-1:0]  m_result_channel,
    input logic                             m_signal_on,
    input logic                             m_compare_load,
    input logic [mcpad_pkg::DATA_W-1:0]     m_compare_value,
    input logic                             m_compare_armed,
    input logic                             m_range_error
);
    import mcpad_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_channel)
            && $stable(m_compare_value) && $stable(m_signal_on))
        else $error("result changed while stalled");

    // a load only happens on an armed channel
    a_load_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_load |-> m_compare_armed)
        else $error("compare load on disarmed channel");

    // a disarmed channel is never on
    a_off_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_compare_armed |-> !m_signal_on)
        else $error("signal on while disarmed");

    // a range error only comes with a new check time
    a_err_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_compare_load)
        else $error("range error without compare load");

endmodule

bind multi_channel_pulse_alive_detector mcpad_checker u_mcpad_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result_channel (m_result_channel),
    .m_signal_on      (m_signal_on),
    .m_compare_load   (m_compare_load),
    .m_compare_value  (m_compare_value),
    .m_compare_armed  (m_compare_armed),
    .m_range_error    (m_range_error)
);

@@ sim/tb_multi_channel_pulse_alive_detector.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the multi channel pulse alive detector
module tb_multi_channel_pulse_alive_detector;
    import mcpad_pkg::*;

    typedef struct packed {
        logic                 op;
        logic [CHANNEL_W-1:0] ch;
        word_t                cap;
        logic                 pin;
    } pulse_event_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic                 on;
        logic                 load;
        word_t                value;
        logic                 armed;
        logic                 err;
    } status_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic                  s_operation     = OP_EDGE;
    logic [CHANNEL_W-1:0]  s_channel       = '0;
    word_t                 s_capture_value = '0;
    logic                  s_pin_level     = 1'b0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [CHANNEL_W-1:0]  m_result_channel;
    logic                  m_signal_on;
    logic                  m_compare_load;
    word_t                 m_compare_value;
    logic                  m_compare_armed;
    logic                  m_range_error;

    pulse_event_t pending_events[$];
    status_t      expected_status[$];
    pulse_event_t on_wire;
    chan_state_t  chan_model[SLOT_COUNT];
    word_t        alive_ticks = ALIVE_RESET;
    word_t        wrap_ticks  = TIMER_RESET;
    logic         steady      = 1'b0;
    int           mismatches  = 0;

    multi_channel_pulse_alive_detector i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_channel        (s_channel),
        .s_capture_value  (s_capture_value),
        .s_pin_level      (s_pin_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_channel (m_result_channel),
        .m_signal_on      (m_signal_on),
        .m_compare_load   (m_compare_load),
        .m_compare_value  (m_compare_value),
        .m_compare_armed  (m_compare_armed),
        .m_range_error    (m_range_error)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic word_t next_tick(input word_t base, output logic err);
        logic [DATA_W:0] total;
        total = {1'b0, base} + {1'b0, alive_ticks};
        if (total >= {1'b0, wrap_ticks}) begin
            total = total - {1'b0, wrap_ticks};
        end
        err = (base >= wrap_ticks) || (alive_ticks >= wrap_ticks);
        return total[DATA_W-1:0];
    endfunction

    function automatic status_t predict_status(input pulse_event_t ev);
        status_t     st;
        chan_state_t c;
        logic        err;
        st    = '0;
        st.ch = ev.ch;
        err   = 1'b0;
        if (int'(ev.ch) >= NUM_CHANNELS) begin
            return st;
        end
        c = chan_model[ev.ch];
        if (ev.op == OP_EDGE) begin
            if (c.edge_count != COUNT_MAX) begin
                c.edge_count = c.edge_count + 1'b1;
            end
            if (c.awaiting_first_edge) begin
                c.next_check_time     = next_tick(ev.cap, err);
                c.awaiting_first_edge = 1'b0;
                st.load               = 1'b1;
            end
        end else if (!c.awaiting_first_edge) begin
            if (c.edge_count > c.checked_count || !ev.pin) begin
                c.channel_on      = 1'b1;
                c.checked_count   = c.edge_count;
                c.next_check_time = next_tick(c.next_check_time, err);
                st.load           = 1'b1;
            end else begin
                c = CHAN_RESET;
            end
        end
        chan_model[ev.ch] = c;
        st.on    = c.channel_on;
        st.value = c.next_check_time;
        st.armed = !c.awaiting_first_edge;
        st.err   = err;
        return st;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic add_event(input logic op, input logic [CHANNEL_W-1:0] ch,
                             input word_t cap, input logic pin);
        pending_events.push_back('{op: op, ch: ch, cap: cap, pin: pin});
    endtask

    task automatic write_register(input logic reg_sel, input word_t value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, {REG_SEL_BIT{1'b0}}};
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_ALIVE) begin
            alive_ticks = value;
        end else begin
            wrap_ticks = value;
        end
    endtask

    task automatic wait_drained;
        while (pending_events.size() != 0 || s_valid || expected_status.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic word_t random_capture();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return word_t'($urandom_range(int'(wrap_ticks) - 1));
        end else if (pick < 85) begin
            return word_t'($urandom);
        end
        case ($urandom_range(3))
            0: begin
                return '0;
            end
            1: begin
                return COUNT_MAX;
            end
            2: begin
                return wrap_ticks - 1'b1;
            end
            default: begin
                return wrap_ticks;
            end
        endcase
    endfunction

    // mostly pulse trains per channel, some stray events
    task automatic add_random_traffic(input int count);
        int                   made;
        int                   rounds;
        int                   edges;
        logic [CHANNEL_W-1:0] ch;
        made = 0;
        while (made < count) begin
            ch = CHANNEL_W'($urandom_range(NUM_CHANNELS - 1));
            if ($urandom_range(99) < 75) begin
                rounds = $urandom_range(4, 1);
                repeat (rounds) begin
                    edges = $urandom_range(3);
                    repeat (edges) begin
                        add_event(OP_EDGE, ch, random_capture(), 1'($urandom));
                        made++;
                    end
                    add_event(OP_CHECK, ch, word_t'($urandom), $urandom_range(99) < 70);
                    made++;
                end
            end else begin
                add_event(1'($urandom), ch, random_capture(), 1'($urandom));
                made++;
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_status.push_back(predict_status(on_wire));
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                    on_wire = pending_events.pop_front();
                    s_valid         <= 1'b1;
                    s_operation     <= on_wire.op;
                    s_channel       <= on_wire.ch;
                    s_capture_value <= on_wire.cap;
                    s_pin_level     <= on_wire.pin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : result_check
        status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 20);
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_status.pop_front();
                    if (m_result_channel !== want.ch)
                        report_mismatch($sformatf("result_channel got %0d want %0d",
                                                  m_result_channel, want.ch));
                    if (m_signal_on !== want.on)
                        report_mismatch($sformatf("ch %0d signal_on got %b want %b",
                                                  want.ch, m_signal_on, want.on));
                    if (m_compare_load !== want.load)
                        report_mismatch($sformatf("ch %0d compare_load got %b want %b",
                                                  want.ch, m_compare_load, want.load));
                    if (m_compare_value !== want.value)
                        report_mismatch($sformatf("ch %0d compare_value got %0d want %0d",
                                                  want.ch, m_compare_value, want.value));
                    if (m_compare_armed !== want.armed)
                        report_mismatch($sformatf("ch %0d compare_armed got %b want %b",
                                                  want.ch, m_compare_armed, want.armed));
                    if (m_range_error !== want.err)
                        report_mismatch($sformatf("ch %0d range_error got %b want %b",
                                                  want.ch, m_range_error, want.err));
                end
            end
        end
    end

    initial begin : stimulus
        word_t alive_next;
        word_t timer_next;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            chan_model[i] = CHAN_RESET;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed at reset periods
        add_event(OP_EDGE,  2'd0, 16'd0,     1'b1);
        add_event(OP_CHECK, 2'd0, 16'd0,     1'b1);
        add_event(OP_CHECK, 2'd0, 16'd0,     1'b1);
        add_event(OP_CHECK, 2'd0, 16'hffff,  1'b0);
        add_event(OP_EDGE,  2'd1, 16'hffff,  1'b0);
        add_event(OP_EDGE,  2'd1, 16'd9999,  1'b1);
        add_event(OP_CHECK, 2'd1, 16'd0,     1'b1);
        add_event(OP_EDGE,  2'd2, 16'd9999,  1'b0);
        add_event(OP_CHECK, 2'd2, 16'd0,     1'b0);
        add_event(OP_CHECK, 2'd2, 16'hffff,  1'b0);
        add_event(OP_CHECK, 2'd2, 16'd0,     1'b1);
        add_event(OP_EDGE,  2'd3, 16'd10000, 1'b1);
        add_event(OP_EDGE,  2'd3, 16'd8999,  1'b0);
        add_event(OP_CHECK, 2'd3, 16'd0,     1'b1);
        add_event(OP_EDGE,  2'd0, 16'h8000,  1'b1);
        add_event(OP_CHECK, 2'd0, 16'h7fff,  1'b0);
        add_event(OP_CHECK, 2'd1, 16'd0,     1'b0);
        wait_drained();

        // back to back traffic, no idling on either side
        steady = 1'b1;
        add_random_traffic(100);
        wait_drained();
        steady = 1'b0;

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                1: begin
                    alive_next = 16'd1;
                    timer_next = 16'd2;
                end
                2: begin
                    alive_next = 16'hffff;
                    timer_next = 16'hffff;
                end
                3: begin
                    alive_next = 16'hffff;
                    timer_next = 16'd2;
                end
                4: begin
                    alive_next = 16'd1;
                    timer_next = 16'hffff;
                end
                5: begin
                    alive_next = word_t'($urandom_range(65535, 1));
                    timer_next = word_t'($urandom_range(65535, 2));
                end
                default: begin
                    timer_next = word_t'($urandom_range(300, 2));
                    alive_next = word_t'($urandom_range(int'(timer_next) - 1, 1));
                end
            endcase
            if (phase != 0) begin
                write_register(REG_ALIVE, alive_next);
                write_register(REG_TIMER, timer_next);
            end
            add_random_traffic(190);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("multi_channel_pulse_alive_detector regression: pass");
        end else begin
            $display("multi_channel_pulse_alive_detector regression: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("multi_channel_pulse_alive_detector regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mcpad_pkg.sv
sv/multi_channel_pulse_alive_detector.sv
sv/mcpad_checker.sv
sim/tb_multi_channel_pulse_alive_detector.sv
